// File: hw/rtl/sensor_hub_gyro_report_parser_defines.svh
// Assertion macros for the sensor hub gyro report parser.
// Included by the top-level RTL file, which carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef SENSOR_HUB_GYRO_REPORT_PARSER_DEFINES_SVH
`define SENSOR_HUB_GYRO_REPORT_PARSER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define SHGP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SHGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/shgp_pkg.sv
// Shared types and constants for the sensor hub gyro report parser.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package shgp_pkg;

  // Packet framing
  localparam int unsigned MaxPacket  = 512;
  localparam int unsigned LenW       = 15;
  localparam int unsigned PosW       = 10;
  localparam int unsigned HdrBytes   = 4;
  localparam int unsigned GyroBytes  = 10;
  localparam logic [LenW-1:0] LenBad = 15'h7FFF;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPacket);

  // Channels and report identifiers
  localparam logic [7:0] ChanExec   = 8'h01;
  localparam logic [7:0] ChanInput  = 8'h03;
  localparam logic [7:0] IdGyro     = 8'h02;
  localparam logic [7:0] IdTsBase   = 8'hFB;
  localparam logic [7:0] IdTsRebase = 8'hFA;
  localparam logic [3:0] TsSkip     = 4'd4;

  localparam logic [7:0] StaleLimitReset = 8'd5;
  localparam logic [7:0] StaleMax        = 8'hFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_GYRO   = 2'd0,
    KIND_NOTICE = 2'd1,
    KIND_BEAT   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] rate_x;
    logic [15:0] rate_y;
    logic [15:0] rate_z;
    logic [7:0]  beat_number;
    logic [31:0] sample_total;
    logic        recover;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/shgp_in_if.sv
// Request channel of the gyro report parser: packet bytes and ticks.
// Depends on shgp_pkg for the operation type.
`default_nettype none

interface shgp_in_if;
  import shgp_pkg::*;

  logic       valid;
  logic       ready;
  op_e        op;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output op, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input op, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/shgp_out_if.sv
// Result channel of the gyro report parser: samples, notices, heartbeats.
// Depends on shgp_pkg for the result kind type.
`default_nettype none

interface shgp_out_if;
  import shgp_pkg::*;

  logic               valid;
  logic               ready;
  kind_e              kind;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic        [7:0]  beat_number;
  logic        [31:0] sample_total;
  logic               recover;

  modport source (output valid, output kind, output rate_x, output rate_y, output rate_z,
                  output beat_number, output sample_total, output recover, input ready);
  modport sink   (input valid, input kind, input rate_x, input rate_y, input rate_z,
                  input beat_number, input sample_total, input recover, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sensor_hub_gyro_report_parser.sv
// Sensor hub gyro report parser: top level.
// Depends on shgp_pkg, shgp_in_if, shgp_out_if and the assertion macro header.
//
// Usage:
//   in_i carries one request per handshake: a packet byte (op = byte, with
//   first_byte marking header byte 0 of a new packet) or a one-second tick.
//   out_o carries at most one result per request: a gyro sample when a gyro
//   report on the input channel completes, a reset notice on header byte 3
//   of an exec-channel packet with cargo, or a heartbeat on every tick.
//   cfg_we_i/cfg_wdata_i write the stale limit; write only while idle.
// Timing:
//   A request is decoded in the cycle it is accepted; its result appears in
//   the output register on the next cycle. One request is taken every cycle
//   while the single output register is empty or out_o.ready is high.
// Reset:
//   Parser idle, all counters and rate stores zero, stale limit 5.
// Stall:
//   A result waits in the output register while out_o.ready is low; a new
//   request is still taken in the same cycle the waiting result leaves.
`default_nettype none
`include "sensor_hub_gyro_report_parser_defines.svh"

module sensor_hub_gyro_report_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  shgp_in_if.sink         in_i,
  shgp_out_if.source      out_o
);
  import shgp_pkg::*;

  // Header byte positions
  localparam logic [PosW-1:0] HdrLenLo = PosW'(0);
  localparam logic [PosW-1:0] HdrLenHi = PosW'(1);
  localparam logic [PosW-1:0] HdrChan  = PosW'(2);
  localparam logic [PosW-1:0] HdrSeq   = PosW'(3);
  localparam logic [3:0]      GyroLast = 4'(GyroBytes - 1);

  // Configuration and parser state
  logic [7:0]      stale_limit_q;
  logic [PosW-1:0] pos_q, pos_d, pos_e;
  logic [LenW-1:0] len_q, len_d, len_e;
  logic [7:0]      chan_q, chan_d, chan_e;
  logic            ok_q, ok_d, ok_e;
  logic [3:0]      skip_q, skip_d, skip_e;
  logic [3:0]      ri_q, ri_d, ri_e;
  logic [15:0]     cap_q  [3];
  logic [15:0]     cap_d  [3];
  logic [15:0]     last_q [3];
  logic [15:0]     last_d [3];
  logic [15:0]     prev_q [3];
  logic [15:0]     prev_d [3];
  logic [7:0]      stale_q, stale_d, stale_n;
  logic [7:0]      beat_q, beat_d;
  logic [31:0]     sample_q, sample_d;

  // Working signals
  logic            in_acc;
  logic            advance;
  logic            same;
  logic [LenW-1:0] len_full;
  logic [LenW-1:0] remain;
  logic [PosW:0]   pos_inc;
  logic [3:0]      ri_off;
  logic [1:0]      slot;
  logic [7:0]      b;

  // Result register
  result_t res, res_q;
  logic    res_valid;
  logic    out_valid_q;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign b          = in_i.data_byte;

  // Effective state after a possible new-packet restart
  always_comb begin
    ok_e   = ok_q;
    pos_e  = pos_q;
    len_e  = len_q;
    chan_e = chan_q;
    skip_e = skip_q;
    ri_e   = ri_q;
    if (in_i.first_byte) begin
      ok_e   = 1'b1;
      pos_e  = '0;
      len_e  = '0;
      chan_e = '0;
      skip_e = '0;
      ri_e   = '0;
    end
  end

  // Decode one request: tick or packet byte
  always_comb begin
    ok_d      = ok_q;
    pos_d     = pos_q;
    len_d     = len_q;
    chan_d    = chan_q;
    skip_d    = skip_q;
    ri_d      = ri_q;
    cap_d     = cap_q;
    last_d    = last_q;
    prev_d    = prev_q;
    stale_d   = stale_q;
    beat_d    = beat_q;
    sample_d  = sample_q;
    res       = '0;
    res.kind  = KIND_GYRO;
    res_valid = 1'b0;
    advance   = 1'b0;
    same      = 1'b0;
    stale_n   = stale_q;
    len_full  = {b[6:0], len_e[7:0]};
    remain    = len_e - LenW'(pos_e);
    pos_inc   = {1'b0, pos_e} + (PosW+1)'(1);
    ri_off    = ri_e - 4'd4;
    slot      = ri_off[2:1];

    if (in_acc) begin
      if (in_i.op == OP_TICK) begin
        // Heartbeat and stale detection
        res_valid        = 1'b1;
        res.kind         = KIND_BEAT;
        res.rate_x       = last_q[0];
        res.rate_y       = last_q[1];
        res.rate_z       = last_q[2];
        res.beat_number  = beat_q;
        res.sample_total = sample_q;
        beat_d           = beat_q + 8'd1;
        same    = (last_q[0] == prev_q[0]) && (last_q[1] == prev_q[1]) &&
                  (last_q[2] == prev_q[2]);
        if (!same) begin
          stale_n = '0;
        end else if (stale_q != StaleMax) begin
          stale_n = stale_q + 8'd1;
        end
        prev_d = last_q;
        if (stale_n >= stale_limit_q) begin
          res.recover = 1'b1;
          sample_d    = '0;
          stale_d     = '0;
        end else begin
          stale_d = stale_n;
        end
      end else begin
        ok_d   = ok_e;
        pos_d  = pos_e;
        len_d  = len_e;
        chan_d = chan_e;
        skip_d = skip_e;
        ri_d   = ri_e;
        if (ok_e) begin
          advance = 1'b1;
          case (pos_e)
            HdrLenLo: len_d = LenW'(b);
            HdrLenHi: begin
              // Drop bad lengths, clamp long ones
              if (len_full == '0 || len_full == LenBad) begin
                ok_d    = 1'b0;
                advance = 1'b0;
              end else if (len_full > MaxLen) begin
                len_d = MaxLen;
              end else begin
                len_d = len_full;
              end
            end
            HdrChan: chan_d = b;
            HdrSeq: begin
              if (len_e <= LenW'(HdrBytes)) begin
                ok_d    = 1'b0;
                advance = 1'b0;
              end else if (chan_e == ChanExec) begin
                res_valid = 1'b1;
                res.kind  = KIND_NOTICE;
              end
            end
            default: begin
              if (chan_e == ChanInput) begin
                // Cargo: skip timestamps, capture gyro reports
                if (skip_e != '0) begin
                  skip_d = skip_e - 4'd1;
                end else if (ri_e != '0) begin
                  if (ri_e >= 4'd4 && slot != 2'd3) begin
                    if (!ri_e[0]) begin
                      cap_d[slot][7:0] = b;
                    end else begin
                      cap_d[slot][15:8] = b;
                    end
                  end
                  if (ri_e == GyroLast) begin
                    ri_d             = '0;
                    last_d           = cap_d;
                    sample_d         = sample_q + 32'd1;
                    res_valid        = 1'b1;
                    res.kind         = KIND_GYRO;
                    res.rate_x       = cap_d[0];
                    res.rate_y       = cap_d[1];
                    res.rate_z       = cap_d[2];
                    res.sample_total = sample_q + 32'd1;
                  end else begin
                    ri_d = ri_e + 4'd1;
                  end
                end else if (b == IdTsBase || b == IdTsRebase) begin
                  skip_d = TsSkip;
                end else if (b == IdGyro && remain >= LenW'(GyroBytes)) begin
                  ri_d = 4'd1;
                end
              end
            end
          endcase
          // Advance the byte position and close the packet at its end
          if (advance) begin
            if (pos_inc >= (PosW+1)'(HdrBytes) && LenW'(pos_inc) >= len_e) begin
              ok_d  = 1'b0;
              pos_d = '0;
            end else begin
              pos_d = pos_inc[PosW-1:0];
            end
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_limit_q <= StaleLimitReset;
      pos_q         <= '0;
      len_q         <= '0;
      chan_q        <= '0;
      ok_q          <= 1'b0;
      skip_q        <= '0;
      ri_q          <= '0;
      cap_q         <= '{default: '0};
      last_q        <= '{default: '0};
      prev_q        <= '{default: '0};
      stale_q       <= '0;
      beat_q        <= '0;
      sample_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stale_limit_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      len_q    <= len_d;
      chan_q   <= chan_d;
      ok_q     <= ok_d;
      skip_q   <= skip_d;
      ri_q     <= ri_d;
      cap_q    <= cap_d;
      last_q   <= last_d;
      prev_q   <= prev_d;
      stale_q  <= stale_d;
      beat_q   <= beat_d;
      sample_q <= sample_d;
      // Load a fresh result or drop the one just taken
      if (in_acc) begin
        out_valid_q <= res_valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.rate_x       = res_q.rate_x;
  assign out_o.rate_y       = res_q.rate_y;
  assign out_o.rate_z       = res_q.rate_z;
  assign out_o.beat_number  = res_q.beat_number;
  assign out_o.sample_total = res_q.sample_total;
  assign out_o.recover      = res_q.recover;

  // Assertions
  `SHGP_ASSERT_SAME(a_ri_range, 1'b1, ri_q <= GyroLast, "gyro report index out of range")
  `SHGP_ASSERT_SAME(a_skip_ri_excl, skip_q != '0, ri_q == '0, "timestamp skip inside gyro report")
  `SHGP_ASSERT_SAME(a_pos_in_pkt, ok_q, pos_q < PosW'(HdrBytes) || LenW'(pos_q) < len_q, "byte position past packet end")
  `SHGP_ASSERT_NEXT(a_recover_clr, in_acc && in_i.op == OP_TICK && res.recover, stale_q == '0 && sample_q == '0, "recovery did not clear counters")

endmodule

`default_nettype wire

// File: tb/sv/sensor_hub_gyro_report_parser_chk.sv
`timescale 1ns / 1ps
// Result checker for the sensor hub gyro report parser testbench: watches both channels
// and the stale limit port, predicts every result and compares it field by field.
// Depends on shgp_pkg, shgp_in_if and shgp_out_if.
module sensor_hub_gyro_report_parser_chk (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  shgp_in_if         req_i,
  shgp_out_if        res_i,
  output int         fail_count_o,
  output int         pending_o
);
  import shgp_pkg::*;

  // Parser state as the block should hold it
  logic [7:0]  stale_limit_q;
  logic [9:0]  pos_q;
  logic [14:0] len_q;
  logic [7:0]  chan_q;
  logic        in_packet_q;
  logic [3:0]  skip_q;
  logic [3:0]  gyro_idx_q;
  logic [15:0] capture_q [3];
  logic [15:0] rates_q [3];
  logic [15:0] prev_rates_q [3];
  logic [7:0]  stale_q;
  logic [7:0]  beat_q;
  logic [31:0] samples_q;

  // Results still owed by the parser, oldest first
  result_t due_reports [$];

  // Advance the parser state by one request; return 1 when it yields a result
  function automatic bit parse_request(input op_e op, input logic [7:0] b, input logic first,
                                       output result_t res);
    bit same;
    bit emit;
    int remain;
    int slot;
    res  = '0;
    emit = 1'b0;

    // Heartbeat carries the state from before this tick
    if (op == OP_TICK) begin
      res.kind         = KIND_BEAT;
      res.rate_x       = rates_q[0];
      res.rate_y       = rates_q[1];
      res.rate_z       = rates_q[2];
      res.beat_number  = beat_q;
      res.sample_total = samples_q;
      beat_q = beat_q + 8'd1;
      same = (rates_q[0] == prev_rates_q[0]) && (rates_q[1] == prev_rates_q[1]) &&
             (rates_q[2] == prev_rates_q[2]);
      if (!same) begin
        stale_q = '0;
      end else if (stale_q != StaleMax) begin
        stale_q = stale_q + 8'd1;
      end
      prev_rates_q = rates_q;
      if (stale_q >= stale_limit_q) begin
        res.recover = 1'b1;
        samples_q   = '0;
        stale_q     = '0;
      end
      return 1'b1;
    end

    // A first byte restarts the framer whatever was in flight
    if (first) begin
      in_packet_q = 1'b1;
      pos_q       = '0;
      len_q       = '0;
      chan_q      = '0;
      skip_q      = '0;
      gyro_idx_q  = '0;
    end
    if (!in_packet_q) return 1'b0;

    case (pos_q)
      10'd0: len_q = {7'd0, b};
      10'd1: begin
        len_q = {b[6:0], len_q[7:0]};
        if (len_q == '0 || len_q == LenBad) begin
          in_packet_q = 1'b0;
          return 1'b0;
        end
        if (len_q > MaxLen) len_q = MaxLen;
      end
      10'd2: chan_q = b;
      10'd3: begin
        if (len_q <= LenW'(HdrBytes)) begin
          in_packet_q = 1'b0;
          return 1'b0;
        end
        if (chan_q == ChanExec) begin
          res.kind = KIND_NOTICE;
          emit     = 1'b1;
        end
      end
      default: begin
        if (chan_q == ChanInput) begin
          remain = int'(len_q) - int'(pos_q);
          if (skip_q != '0) begin
            skip_q = skip_q - 4'd1;
          end else if (gyro_idx_q != '0) begin
            // Report bytes 4..9 hold x, y, z little-endian
            if (gyro_idx_q >= 4'd4) begin
              slot = (int'(gyro_idx_q) - 4) / 2;
              if (gyro_idx_q[0]) capture_q[slot][15:8] = b;
              else capture_q[slot][7:0] = b;
            end
            if (gyro_idx_q == GyroBytes - 1) begin
              gyro_idx_q       = '0;
              rates_q          = capture_q;
              samples_q        = samples_q + 32'd1;
              res.kind         = KIND_GYRO;
              res.rate_x       = rates_q[0];
              res.rate_y       = rates_q[1];
              res.rate_z       = rates_q[2];
              res.sample_total = samples_q;
              emit             = 1'b1;
            end else begin
              gyro_idx_q = gyro_idx_q + 4'd1;
            end
          end else if (b == IdTsBase || b == IdTsRebase) begin
            skip_q = TsSkip;
          end else if (b == IdGyro && remain >= int'(GyroBytes)) begin
            gyro_idx_q = 4'd1;
          end
        end
      end
    endcase

    // Close the packet once the clamped length is used up
    pos_q = pos_q + 10'd1;
    if (pos_q >= HdrBytes && pos_q >= len_q) begin
      in_packet_q = 1'b0;
      pos_q       = '0;
    end
    return emit;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t predicted;
    result_t want;
    if (!rst_ni) begin
      stale_limit_q = StaleLimitReset;
      pos_q         = '0;
      len_q         = '0;
      chan_q        = '0;
      in_packet_q   = 1'b0;
      skip_q        = '0;
      gyro_idx_q    = '0;
      capture_q     = '{default: '0};
      rates_q       = '{default: '0};
      prev_rates_q  = '{default: '0};
      stale_q       = '0;
      beat_q        = '0;
      samples_q     = '0;
      due_reports.delete();
      pending_o     = 0;
    end else begin
      if (cfg_we_i) stale_limit_q = cfg_wdata_i;

      // Compare an accepted result with the oldest one owed
      if (res_i.valid && res_i.ready) begin
        if (due_reports.size() == 0) begin
          $error("result of kind %0d arrived with none awaited", res_i.kind);
          fail_count_o++;
        end else begin
          want = due_reports.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_i.kind));
          check_field("rate_x", {16'h0, want.rate_x}, {16'h0, res_i.rate_x});
          check_field("rate_y", {16'h0, want.rate_y}, {16'h0, res_i.rate_y});
          check_field("rate_z", {16'h0, want.rate_z}, {16'h0, res_i.rate_z});
          check_field("beat_number", {24'h0, want.beat_number}, {24'h0, res_i.beat_number});
          check_field("sample_total", want.sample_total, res_i.sample_total);
          check_field("recover", {31'h0, want.recover}, {31'h0, res_i.recover});
        end
      end

      // Predict from the request taken at this edge
      if (req_i.valid && req_i.ready) begin
        if (parse_request(req_i.op, req_i.data_byte, req_i.first_byte, predicted)) begin
          due_reports.push_back(predicted);
        end
      end
      pending_o = due_reports.size();
    end
  end

endmodule

// File: tb/sv/sensor_hub_gyro_report_parser_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sensor hub gyro report parser: clock, reset, request and result
// pacing, stale limit writes and the verdict. Depends on shgp_pkg, the channel interfaces,
// the parser and sensor_hub_gyro_report_parser_chk.
module sensor_hub_gyro_report_parser_tb;
  import shgp_pkg::*;

  localparam int ReqTarget = 1650;
  localparam int IdleLimit = 2000;

  typedef logic [7:0] byte_q_t [$];

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         awaited;
  int         sent;
  int         idle_cycles;
  bit         steady_src;
  logic [15:0] gyro_last [3];

  shgp_in_if  req_if ();
  shgp_out_if res_if ();

  sensor_hub_gyro_report_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  sensor_hub_gyro_report_parser_chk chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (awaited)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Header of four bytes; the ignored top bit of the length is random
  function automatic byte_q_t frame(input logic [14:0] len, input logic [7:0] chan,
                                    input byte_q_t cargo);
    byte_q_t pkt;
    pkt.push_back(len[7:0]);
    pkt.push_back({1'($urandom), len[14:8]});
    pkt.push_back(chan);
    pkt.push_back(8'($urandom));
    foreach (cargo[i]) pkt.push_back(cargo[i]);
    return pkt;
  endfunction

  // Gyro report of ten bytes; reuse repeats the last rates so that the stale count climbs
  function automatic byte_q_t gyro_report(input bit reuse);
    byte_q_t rep;
    rep.push_back(IdGyro);
    repeat (3) rep.push_back(8'($urandom));
    for (int k = 0; k < 3; k++) begin
      if (!reuse) begin
        case ($urandom_range(0, 7))
          0: gyro_last[k] = 16'h8000;
          1: gyro_last[k] = 16'h7FFF;
          2: gyro_last[k] = 16'h0000;
          3: gyro_last[k] = 16'hFFFF;
          default: gyro_last[k] = 16'($urandom);
        endcase
      end
      rep.push_back(gyro_last[k][7:0]);
      rep.push_back(gyro_last[k][15:8]);
    end
    return rep;
  endfunction

  function automatic byte_q_t stamp_report();
    byte_q_t rep;
    rep.push_back($urandom_range(0, 1) ? IdTsBase : IdTsRebase);
    repeat (4) rep.push_back(8'($urandom));
    return rep;
  endfunction

  // Input channel cargo: gyro and timestamp reports with the odd stray byte
  function automatic byte_q_t input_cargo(input int n);
    byte_q_t c;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) c = {c, gyro_report($urandom_range(0, 9) < 4)};
      else if (pick < 8) c = {c, stamp_report()};
      else repeat ($urandom_range(1, 3)) c.push_back(8'($urandom));
    end
    return c;
  endfunction

  // Offer one request at a falling edge and hold it until it is taken
  task automatic send_req(input op_e op, input logic [7:0] b, input logic first);
    int gap;
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.op         = op;
    req_if.data_byte  = b;
    req_if.first_byte = first;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_req(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_bytes(input byte_q_t bytes);
    foreach (bytes[i]) send_req(OP_BYTE, bytes[i], i == 0);
  endtask

  // Drop valid, drain every owed result, then let the parser fall idle
  task automatic settle();
    req_if.valid = 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic random_step();
    byte_q_t cargo;
    byte_q_t pkt;
    logic [14:0] len;
    logic [7:0]  chan;
    int sel;
    int off;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      repeat ($urandom_range(1, 4)) send_tick();
      return;
    end
    if (sel < 93 && sel >= 88) begin
      // stray bytes; ignored unless a packet is still open
      repeat ($urandom_range(1, 4)) send_req(OP_BYTE, 8'($urandom), 1'b0);
      return;
    end
    if (sel < 60) begin
      cargo = input_cargo($urandom_range(1, 4));
      pkt   = frame(15'(HdrBytes + cargo.size()), ChanInput, cargo);
    end else if (sel < 70) begin
      // length off the mark, sometimes with the tail cut by the next packet
      cargo = input_cargo($urandom_range(1, 3));
      off   = $urandom_range(0, 12) - 4;
      len   = 15'(HdrBytes + cargo.size() + off);
      if (len == '0) len = 15'd1;
      pkt   = frame(len, ChanInput, cargo);
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) void'(pkt.pop_back());
    end else if (sel < 78) begin
      repeat ($urandom_range(0, 6)) cargo.push_back(8'($urandom));
      pkt = frame(15'(HdrBytes + cargo.size()), ChanExec, cargo);
    end else if (sel < 88) begin
      // odd headers: bad, short or huge lengths on any channel
      case ($urandom_range(0, 4))
        0: len = '0;
        1: len = LenBad;
        2: len = 15'($urandom_range(1, 4));
        3: len = 15'($urandom_range(5, 20));
        default: len = 15'($urandom);
      endcase
      chan = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
      repeat ($urandom_range(0, 12)) cargo.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) cargo = {cargo, gyro_report(1'b0)};
      pkt = frame(len, chan, cargo);
    end else if (sel < 99 || $urandom_range(0, 3) != 0) begin
      cargo = {stamp_report(), gyro_report(1'b1)};
      pkt   = frame(15'(HdrBytes + cargo.size()), ChanInput, cargo);
    end else begin
      // rare long packet, clamped to the maximum length
      while (cargo.size() < MaxPacket + 8) cargo = {cargo, gyro_report(1'b0)};
      pkt = frame(15'($urandom_range(MaxPacket + 1, 15'h7FFE)), ChanInput, cargo);
    end
    send_bytes(pkt);
  endtask

  task automatic run_random(input int upto);
    while (sent < upto) begin
      if ($urandom_range(0, 9) == 0) steady_src = !steady_src;
      random_step();
    end
  endtask

  // Result side: runs of ready with stalls of random length between them
  initial begin : result_pacing
    int run;
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      res_if.ready = 1'b1;
      repeat (run) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("** sensor_hub_gyro_report_parser: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    byte_q_t cargo;
    byte_q_t pkt;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_BYTE;
    req_if.data_byte  = '0;
    req_if.first_byte = 1'b0;
    sent              = 0;
    steady_src        = 1'b0;
    gyro_last         = '{default: '0};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // heartbeat straight out of reset
    send_tick();
    // exec channel: notice only when cargo follows the header
    cargo = '{8'($urandom)};
    send_bytes(frame(15'd5, ChanExec, cargo));
    cargo = {};
    send_bytes(frame(15'd4, ChanExec, cargo));
    // zero and all-ones lengths drop the packet; the rest are strays
    send_bytes(frame(15'd0, ChanInput, gyro_report(1'b0)));
    send_bytes(frame(LenBad, ChanInput, gyro_report(1'b0)));
    send_req(OP_BYTE, IdGyro, 1'b0);
    send_req(OP_BYTE, 8'hFF, 1'b0);
    // extreme rates behind both timestamp ids
    gyro_last = '{16'h7FFF, 16'h8000, 16'hFFFF};
    cargo = {stamp_report(), gyro_report(1'b1)};
    cargo[0] = IdTsBase;
    send_bytes(frame(15'(HdrBytes + cargo.size()), ChanInput, cargo));
    gyro_last = '{16'h0000, 16'h00FF, 16'hFF00};
    cargo = {stamp_report(), gyro_report(1'b1)};
    cargo[0] = IdTsRebase;
    send_bytes(frame(15'(HdrBytes + cargo.size()), ChanInput, cargo));
    // gyro id with only nine bytes left is skipped
    cargo = gyro_report(1'b0);
    void'(cargo.pop_back());
    send_bytes(frame(15'(HdrBytes + cargo.size()), ChanInput, cargo));
    // report cut off by a new first byte
    pkt = frame(15'(HdrBytes + GyroBytes), ChanInput, gyro_report(1'b0));
    repeat (4) void'(pkt.pop_back());
    send_bytes(pkt);
    // short packets end after the header; trailing bytes are strays
    for (int n = 1; n <= 4; n++) send_bytes(frame(15'(n), ChanInput, gyro_report(1'b0)));
    // any channel above the input one ignores its cargo
    send_bytes(frame(15'(HdrBytes + GyroBytes), 8'($urandom_range(4, 255)),
                     gyro_report(1'b0)));
    // unchanged rates over enough ticks to reach the reset limit
    repeat (7) send_tick();
    // longest length, clamped to the maximum, with reports running past the end
    cargo = {};
    while (cargo.size() < MaxPacket + 8) cargo = {cargo, gyro_report(1'b0)};
    send_bytes(frame(15'h7FFE, ChanInput, cargo));
    send_tick();

    // random phases under several stale limits
    settle();
    write_limit(8'd1);
    run_random(sent + 250);
    settle();
    write_limit(8'd255);
    repeat (258) send_tick();
    run_random(sent + 150);
    settle();
    write_limit(8'($urandom_range(2, 254)));
    run_random(sent + 250);
    settle();
    write_limit(8'($urandom_range(2, 8)));
    run_random((ReqTarget > sent + 100) ? ReqTarget : sent + 100);

    settle();
    if (fail_count == 0 && awaited == 0) begin
      $display("** sensor_hub_gyro_report_parser: PASSED **");
    end else begin
      $display("** sensor_hub_gyro_report_parser: FAILED **");
    end
    $finish;
  end

endmodule
